### src/vpr_pkg.sv
package vpr_pkg;

	// datapath width holds a 33-bit difference grown by the cordic gain
	localparam int DW = 36;
	// split point of a datapath word for the gain multiply
	localparam int HW = 18;
	// width of a gain-scaled value
	localparam int SW = DW + 1;

	localparam logic [63:0] GAIN_Q32 = 64'h0000_0000_9B74_EDA8;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] ANGLE_ROUND = 32'h0000_8000;

	typedef enum logic [1:0] {
		OP_POLAR   = 2'd0,
		OP_MEASURE = 2'd1,
		OP_ROTATE  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ROT  = 2'd1,
		KIND_MEAS = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic signed [DW-1:0]  x;
		logic signed [DW-1:0]  y;
		logic [31:0]           z;
	} cordic_t;

	// atan(2^-i) in 32-bit turns
	function automatic logic [31:0] atan_turn(input int unsigned idx);
		logic [31:0] a;
		case (idx)
			0:  a = 32'h2000_0000;
			1:  a = 32'h12E4_051E;
			2:  a = 32'h09FB_385B;
			3:  a = 32'h0511_11D4;
			4:  a = 32'h028B_0D43;
			5:  a = 32'h0145_D7E1;
			6:  a = 32'h00A2_F61E;
			7:  a = 32'h0051_7C55;
			8:  a = 32'h0028_BE53;
			9:  a = 32'h0014_5F2F;
			10: a = 32'h000A_2F98;
			11: a = 32'h0005_17CC;
			12: a = 32'h0002_8BE6;
			13: a = 32'h0001_45F3;
			14: a = 32'h0000_A2FA;
			15: a = 32'h0000_517D;
			16: a = 32'h0000_28BE;
			17: a = 32'h0000_145F;
			18: a = 32'h0000_0A30;
			19: a = 32'h0000_0518;
			20: a = 32'h0000_028C;
			21: a = 32'h0000_0146;
			22: a = 32'h0000_00A3;
			23: a = 32'h0000_0051;
			24: a = 32'h0000_0029;
			25: a = 32'h0000_0014;
			26: a = 32'h0000_000A;
			27: a = 32'h0000_0005;
			28: a = 32'h0000_0003;
			29: a = 32'h0000_0001;
			30: a = 32'h0000_0001;
			default: a = 32'h0000_0000;
		endcase
		return a;
	endfunction

endpackage

### src/vpr_stage.sv
module vpr_stage #(
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vpr_pkg::cordic_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output vpr_pkg::cordic_t out_data
);
	import vpr_pkg::*;

	localparam logic [31:0] ATAN = atan_turn(SHIFT % 32);

	logic signed [DW-1:0] x_in;
	logic signed [DW-1:0] y_in;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic                 cw;
	cordic_t              nxt;
	logic                 valid_q;
	cordic_t              data_q;

	always_comb begin
		x_in = in_data.x;
		y_in = in_data.y;
		dx = y_in >>> SHIFT;
		dy = x_in >>> SHIFT;
		// vectoring steers by the sign of y, rotation by the sign of the angle left
		cw = (in_data.kind == KIND_MEAS) ? !y_in[DW-1] : in_data.z[31];
		nxt.kind = in_data.kind;
		if (cw) begin
			nxt.x = x_in + dx;
			nxt.y = y_in - dy;
			nxt.z = in_data.z + ATAN;
		end else begin
			nxt.x = x_in - dx;
			nxt.y = y_in + dy;
			nxt.z = in_data.z - ATAN;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

### src/vpr_scale.sv
module vpr_scale #(
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  vpr_pkg::cordic_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      out_x,
	output logic [31:0]      out_y,
	output logic [33:0]      magnitude,
	output logic [15:0]      angle_out
);
	import vpr_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam logic [63:0] K_FULL = (GAIN_Q32 + (64'd1 << (31 - F))) >> (32 - F);
	localparam logic [F-1:0] GAIN_K = K_FULL[F-1:0];
	localparam logic signed [F:0] GAIN_KS = {1'b0, GAIN_K};
	localparam int LW = HW + F;
	localparam int UW = DW - HW + F + 1;
	localparam int PW = DW + F + 1;
	localparam logic [PW-1:0] RND = PW'(64'd1 << (F - 1));

	// partial products
	logic                 valid_s1;
	kind_t                kind_s1;
	logic [31:0]          z_s1;
	logic [LW-1:0]        xl_s1;
	logic [LW-1:0]        yl_s1;
	logic signed [UW-1:0] xh_s1;
	logic signed [UW-1:0] yh_s1;
	logic                 ready_s1;

	// scaled values
	logic                 valid_s2;
	kind_t                kind_s2;
	logic [31:0]          z_s2;
	logic signed [SW-1:0] sx_s2;
	logic signed [SW-1:0] sy_s2;
	logic                 ready_s2;

	logic                 valid_q;
	logic [31:0]          out_x_q;
	logic [31:0]          out_y_q;
	logic [33:0]          mag_q;
	logic [15:0]          ang_q;
	logic                 ready_q;

	logic signed [PW-1:0] sum_x;
	logic signed [PW-1:0] sum_y;
	logic [31:0]          ang_sum;
	logic [31:0]          sat_x;
	logic [31:0]          sat_y;
	logic [33:0]          sat_m;

	function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
		logic [31:0] r;
		if (!v[SW-1] && (|v[SW-2:31])) begin
			r = 32'h7FFF_FFFF;
		end else if (v[SW-1] && !(&v[SW-2:31])) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign ready_q = !valid_q || out_ready;
	assign ready_s2 = !valid_s2 || ready_q;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		sum_x = ($signed(PW'(xh_s1)) <<< HW) + $signed(PW'(xl_s1)) + $signed(RND);
		sum_y = ($signed(PW'(yh_s1)) <<< HW) + $signed(PW'(yl_s1)) + $signed(RND);
		ang_sum = z_s2 + ANGLE_ROUND;
		sat_x = sat32(sx_s2);
		sat_y = sat32(sy_s2);
		if (sx_s2[SW-1]) begin
			sat_m = '0;
		end else if (|sx_s2[SW-2:34]) begin
			sat_m = '1;
		end else begin
			sat_m = sx_s2[33:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_q) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			kind_s1 <= in_data.kind;
			z_s1 <= in_data.z;
			xl_s1 <= in_data.x[HW-1:0] * GAIN_K;
			yl_s1 <= in_data.y[HW-1:0] * GAIN_K;
			xh_s1 <= $signed(in_data.x[DW-1:HW]) * GAIN_KS;
			yh_s1 <= $signed(in_data.y[DW-1:HW]) * GAIN_KS;
		end
		if (ready_s2 && valid_s1) begin
			kind_s2 <= kind_s1;
			z_s2 <= z_s1;
			sx_s2 <= SW'(sum_x >>> F);
			sy_s2 <= SW'(sum_y >>> F);
		end
		if (ready_q && valid_s2) begin
			case (kind_s2)
				KIND_ROT: begin
					out_x_q <= sat_x;
					out_y_q <= sat_y;
					mag_q <= '0;
					ang_q <= '0;
				end
				KIND_MEAS: begin
					out_x_q <= '0;
					out_y_q <= '0;
					mag_q <= sat_m;
					ang_q <= ang_sum[31:16];
				end
				default: begin
					out_x_q <= '0;
					out_y_q <= '0;
					mag_q <= '0;
					ang_q <= '0;
				end
			endcase
		end
	end

	assign out_valid = valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign magnitude = mag_q;
	assign angle_out = ang_q;

endmodule

### src/vector_polar_rotate_unit.sv
// two setup stages, one stage per micro-rotation and three gain and saturation stages
// throughput: one beat per cycle while m_tready is high; each stage holds its beat
// while the next one is full, so the pipeline keeps filling while a result waits
// at the output register
// reset: arst_n clears every valid bit asynchronously; data registers are not reset
module vector_polar_rotate_unit #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, ref_x, ref_y, angle_in, radius, zero pad
	input  logic [175:0] s_tdata,
	// op
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, magnitude, angle_out, zero pad
	output logic [119:0] m_tdata
);
	import vpr_pkg::*;

	op_t                 op;
	logic signed [31:0]  point_x;
	logic signed [31:0]  point_y;
	logic signed [31:0]  ref_x;
	logic signed [31:0]  ref_y;
	logic [15:0]         angle_in;
	logic [30:0]         radius;
	logic [31:0]         ang32;
	logic                flip;
	logic signed [DW-1:0] x0;
	logic signed [DW-1:0] y0;
	cordic_t             nxt_s1;
	cordic_t             nxt_s2;

	logic    valid_s1;
	cordic_t data_s1;
	logic    ready_s1;
	logic    valid_s2;
	cordic_t data_s2;
	logic    ready_s2;

	logic    valid_c [0:CORDIC_STAGES];
	logic    ready_c [0:CORDIC_STAGES];
	cordic_t data_c [0:CORDIC_STAGES];

	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [33:0] magnitude;
	logic [15:0] angle_out;

	always_comb begin
		op = op_t'(s_tuser);
		point_x = s_tdata[31:0];
		point_y = s_tdata[63:32];
		ref_x = s_tdata[95:64];
		ref_y = s_tdata[127:96];
		angle_in = s_tdata[143:128];
		radius = s_tdata[174:144];
		ang32 = {angle_in, 16'h0000};
		// outside [-1/4, 1/4) turn: take out a half turn and negate the point
		flip = ang32[31] ^ ang32[30];
		x0 = '0;
		y0 = '0;
		nxt_s1.kind = KIND_NONE;
		nxt_s1.x = '0;
		nxt_s1.y = '0;
		nxt_s1.z = '0;
		case (op)
			OP_POLAR: begin
				x0 = DW'(radius);
				nxt_s1.kind = KIND_ROT;
				nxt_s1.x = flip ? -x0 : x0;
				nxt_s1.y = '0;
				nxt_s1.z = {ang32[31] ^ flip, ang32[30:0]};
			end
			OP_ROTATE: begin
				x0 = DW'(point_x);
				y0 = DW'(point_y);
				nxt_s1.kind = KIND_ROT;
				nxt_s1.x = flip ? -x0 : x0;
				nxt_s1.y = flip ? -y0 : y0;
				nxt_s1.z = {ang32[31] ^ flip, ang32[30:0]};
			end
			OP_MEASURE: begin
				nxt_s1.kind = KIND_MEAS;
				nxt_s1.x = DW'(point_x) - DW'(ref_x);
				nxt_s1.y = DW'(point_y) - DW'(ref_y);
				nxt_s1.z = '0;
			end
			default: begin
				nxt_s1.kind = KIND_NONE;
			end
		endcase
	end

	// vectoring setup: coinciding points give all zeros, left half plane folds over
	always_comb begin
		nxt_s2 = data_s1;
		if (data_s1.kind == KIND_MEAS) begin
			if (data_s1.x == '0 && data_s1.y == '0) begin
				nxt_s2.kind = KIND_NONE;
			end else if (data_s1.x[DW-1]) begin
				nxt_s2.x = -data_s1.x;
				nxt_s2.y = -data_s1.y;
				nxt_s2.z = HALF_TURN;
			end
		end
	end

	assign ready_s2 = !valid_s2 || ready_c[0];
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			data_s1 <= nxt_s1;
		end
		if (ready_s2 && valid_s1) begin
			data_s2 <= nxt_s2;
		end
	end

	assign valid_c[0] = valid_s2;
	assign data_c[0] = data_s2;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		vpr_stage #(
			.SHIFT(i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_ready (ready_c[i]),
			.in_data  (data_c[i]),
			.out_valid(valid_c[i+1]),
			.out_ready(ready_c[i+1]),
			.out_data (data_c[i+1])
		);
	end

	vpr_scale #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[CORDIC_STAGES]),
		.in_ready (ready_c[CORDIC_STAGES]),
		.in_data  (data_c[CORDIC_STAGES]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_x    (out_x),
		.out_y    (out_y),
		.magnitude(magnitude),
		.angle_out(angle_out)
	);

	assign m_tdata = {6'b0, angle_out, magnitude, out_y, out_x};

`ifndef SYNTHESIS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	a_measure_no_xy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (magnitude != '0 || angle_out != '0) |-> out_x == '0 && out_y == '0)
		else $error("measure beat carries x or y");

	a_rotate_no_polar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_x != '0 |-> magnitude == '0 && angle_out == '0)
		else $error("rotate beat carries magnitude or angle");
`endif

endmodule
